@@ rtl/rgbhsl_pkg.sv @@
// Package for the RGB to HSL converter: channel and divider operand types,
// plus the fixed constants of the conversion. No dependencies.
`timescale 1ns / 1ps

package rgbhsl_pkg;

  // Width of one colour channel
  localparam int unsigned CHAN_W = 8;
  // Operand widths of the three divider lanes (numerator never exceeds divisor)
  localparam int unsigned HDEN_W = 11;  // six times the channel range, up to 1530
  localparam int unsigned SDEN_W = 8;   // sum or 510 minus sum, up to 255
  localparam int unsigned LDEN_W = 9;   // fixed 510

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [HDEN_W-1:0] hden_t;
  typedef logic [SDEN_W-1:0] sden_t;
  typedef logic [LDEN_W-1:0] lden_t;

  // Lightness divisor: twice full scale
  localparam lden_t LIG_DEN   = lden_t'(510);
  // Half of the lightness divisor: sums above this use the upper saturation form
  localparam lden_t SUM_HALF  = lden_t'(255);
  // Dummy divisors for a grey pixel, where the numerators are zero
  localparam hden_t HUE_GREY_DEN = hden_t'(6);
  localparam sden_t SAT_GREY_DEN = sden_t'(1);

endpackage

@@ rtl/rgbhsl_prep.sv @@
// Front stage of the RGB to HSL converter: max/min, range and sum, and the
// numerator/divisor pairs for the three divider lanes. Uses rgbhsl_pkg.
`timescale 1ns / 1ps

module rgbhsl_prep (
  input  logic               clk,
  input  logic               en,
  input  rgbhsl_pkg::chan_t  red,
  input  rgbhsl_pkg::chan_t  green,
  input  rgbhsl_pkg::chan_t  blue,
  output rgbhsl_pkg::hden_t  hnum_r,
  output rgbhsl_pkg::hden_t  hden_r,
  output rgbhsl_pkg::sden_t  snum_r,
  output rgbhsl_pkg::sden_t  sden_r,
  output rgbhsl_pkg::lden_t  lnum_r
);
  import rgbhsl_pkg::*;

  chan_t mx, mn, d;
  lden_t sum, upper;
  hden_t d6;
  hden_t hnum_nxt, hden_nxt;
  sden_t snum_nxt, sden_nxt;

  // Largest and smallest channel
  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
  end

  assign d     = mx - mn;
  assign sum   = lden_t'(mx) + lden_t'(mn);
  assign upper = LIG_DEN - sum;
  assign d6    = (hden_t'(d) << 2) + (hden_t'(d) << 1);

  // Hue and saturation operands; ties for the max go red, then green, then blue
  always_comb begin
    if (d == '0) begin
      hnum_nxt = '0;
      hden_nxt = HUE_GREY_DEN;
      snum_nxt = '0;
      sden_nxt = SAT_GREY_DEN;
    end else begin
      hden_nxt = d6;
      snum_nxt = sden_t'(d);
      sden_nxt = (sum > SUM_HALF) ? upper[SDEN_W-1:0] : sum[SDEN_W-1:0];
      if (mx == red) begin
        hnum_nxt = (green >= blue) ? hden_t'(green - blue)
                                   : d6 - hden_t'(blue - green);
      end else if (mx == green) begin
        hnum_nxt = (hden_t'(d) << 1) + hden_t'(blue) - hden_t'(red);
      end else begin
        hnum_nxt = (hden_t'(d) << 2) + hden_t'(red) - hden_t'(green);
      end
    end
  end

  // Operand register
  always_ff @(posedge clk) begin
    if (en) begin
      hnum_r <= hnum_nxt;
      hden_r <= hden_nxt;
      snum_r <= snum_nxt;
      sden_r <= sden_nxt;
      lnum_r <= sum;
    end
  end

endmodule

@@ rtl/rgbhsl_div.sv @@
// Pipelined restoring divider lane: one quotient bit per register stage,
// q = floor(num * 2^(Q_W-1) / den) for num <= den. No package dependency.
`timescale 1ns / 1ps

module rgbhsl_div #(
  parameter int unsigned DEN_W = 8,
  parameter int unsigned Q_W   = 14
) (
  input  logic             clk,
  input  logic [Q_W-1:0]   en,
  input  logic [DEN_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   q
);

  logic [DEN_W-1:0] rem_r [Q_W-1];
  logic [DEN_W-1:0] den_r [Q_W-1];
  logic [Q_W-1:0]   q_r   [Q_W];

  genvar k;
  generate
    for (k = 0; k < Q_W; k++) begin : g_stage
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic [DEN_W-1:0] den_in;
      logic             ge;

      // Trial subtract: first stage takes the numerator as is, later ones shift
      if (k == 0) begin : g_first
        assign trial  = {1'b0, num};
        assign den_in = den;
      end else begin : g_next
        assign trial  = {rem_r[k-1], 1'b0};
        assign den_in = den_r[k-1];
      end

      assign diff = trial - {1'b0, den_in};
      assign ge   = (trial >= {1'b0, den_in});

      if (k == 0) begin : g_q_first
        always_ff @(posedge clk) begin
          if (en[k]) q_r[k] <= Q_W'(ge);
        end
      end else begin : g_q_next
        always_ff @(posedge clk) begin
          if (en[k]) q_r[k] <= {q_r[k-1][Q_W-2:0], ge};
        end
      end

      // Partial remainder and divisor travel on, except after the last bit
      if (k < Q_W - 1) begin : g_rem
        always_ff @(posedge clk) begin
          if (en[k]) begin
            rem_r[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            den_r[k] <= den_in;
          end
        end
      end
    end
  endgenerate

  assign q = q_r[Q_W-1];

endmodule

@@ rtl/rgbhsl_flow.sv @@
// Valid/ready control for the converter pipeline: one valid bit per stage,
// each stage loads when it is empty or its successor moves. No dependencies.
`timescale 1ns / 1ps

module rgbhsl_flow #(
  parameter int unsigned DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             out_ready,
  output logic             in_ready,
  output logic             out_valid,
  output logic [DEPTH-1:0] adv
);

  logic [DEPTH-1:0] v_r, v_nxt;

  // Ready ripples back from the output; bubbles are squeezed out
  always_comb begin
    adv[DEPTH-1] = !v_r[DEPTH-1] || out_ready;
    for (int i = DEPTH - 2; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end

  always_comb begin
    v_nxt[0] = adv[0] ? in_valid : v_r[0];
    for (int i = 1; i < DEPTH; i++) begin
      v_nxt[i] = adv[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[DEPTH-1];

`ifndef SYNTHESIS
  // An accepted word occupies the first stage next cycle
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v_r[0])
    else $error("accepted word missing from first stage");

  // An empty pipeline always takes a word
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r == '0) |-> in_ready)
    else $error("empty pipeline not ready");

  // Words in flight change only by what enters and leaves
  a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(v_r) == $past($countones(v_r))
      + $past(int'(in_valid && in_ready)) - $past(int'(out_valid && out_ready))))
    else $error("word lost or duplicated in pipeline");
`endif

endmodule

@@ rtl/rgb_to_hsl_converter.sv @@
// RGB to HSL converter top level: prep stage, three divider lanes, rounding
// output stage and flow control. Uses rgbhsl_pkg, rgbhsl_prep, rgbhsl_div, rgbhsl_flow.
`timescale 1ns / 1ps

// Takes one 8-bit RGB pixel per clock while in_tready is high and returns hue,
// saturation and lightness as unsigned fractions with FRAC_BITS fractional
// bits, rounded to nearest. Throughput is one word per cycle while the output
// does not stall. The pipeline is the operand stage, the restoring dividers,
// which resolve one quotient bit per register stage, and the rounding
// output stage. A stalled output holds its word and the pipeline keeps
// accepting input until every stage is full.

module rgb_to_hsl_converter #(
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  // red [7:0], green [15:8], blue [23:16]
  input  logic [23:0]                               in_tdata,
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  // hue [F-1:0], saturation [2F:F], lightness [3F+1:2F+1], zero fill above
  output logic [((3*FRAC_BITS+2+7)/8)*8-1:0]        out_tdata
);
  import rgbhsl_pkg::*;

  localparam int unsigned Q_W   = FRAC_BITS + 2;
  localparam int unsigned DEPTH = Q_W + 2;
  localparam int unsigned OUT_W = ((3*FRAC_BITS+2+7)/8)*8;

  logic [DEPTH-1:0] adv;
  hden_t hnum, hden;
  sden_t snum, sden;
  lden_t lnum;
  logic [Q_W-1:0] hq, sq, lq;
  logic [Q_W-1:0] hround, sround, lround;
  logic [FRAC_BITS-1:0] hue_nxt, hue_r;
  logic [FRAC_BITS:0]   sat_r, lig_r;

  rgbhsl_flow #(.DEPTH(DEPTH)) u_flow (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .out_ready (out_tready),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .adv       (adv)
  );

  rgbhsl_prep u_prep (
    .clk    (clk),
    .en     (adv[0]),
    .red    (in_tdata[7:0]),
    .green  (in_tdata[15:8]),
    .blue   (in_tdata[23:16]),
    .hnum_r (hnum),
    .hden_r (hden),
    .snum_r (snum),
    .sden_r (sden),
    .lnum_r (lnum)
  );

  rgbhsl_div #(.DEN_W(HDEN_W), .Q_W(Q_W)) u_div_hue (
    .clk (clk),
    .en  (adv[Q_W:1]),
    .num (hnum),
    .den (hden),
    .q   (hq)
  );

  rgbhsl_div #(.DEN_W(SDEN_W), .Q_W(Q_W)) u_div_sat (
    .clk (clk),
    .en  (adv[Q_W:1]),
    .num (snum),
    .den (sden),
    .q   (sq)
  );

  rgbhsl_div #(.DEN_W(LDEN_W), .Q_W(Q_W)) u_div_lig (
    .clk (clk),
    .en  (adv[Q_W:1]),
    .num (lnum),
    .den (LIG_DEN),
    .q   (lq)
  );

  // Round half up from the one-extra-bit quotient; full-turn hue wraps to 0
  assign hround  = hq + Q_W'(1);
  assign sround  = sq + Q_W'(1);
  assign lround  = lq + Q_W'(1);
  assign hue_nxt = hround[Q_W-1] ? '0 : hround[Q_W-2:1];

  // Output register
  always_ff @(posedge clk) begin
    if (adv[DEPTH-1]) begin
      hue_r <= hue_nxt;
      sat_r <= sround[Q_W-1:1];
      lig_r <= lround[Q_W-1:1];
    end
  end

  assign out_tdata = OUT_W'({lig_r, sat_r, hue_r});

endmodule

@@ sim/tb_rgb_to_hsl_converter.sv @@
// Self-checking testbench for rgb_to_hsl_converter: directed table and random pixels,
// checked word by word against an integer HSL predictor. Depends on rgbhsl_pkg and the RTL.
`timescale 1ns / 1ps

module tb_rgb_to_hsl_converter;
  import rgbhsl_pkg::*;

  localparam int unsigned FRAC     = 12;
  localparam int unsigned OUT_W    = ((3*FRAC+2+7)/8)*8;
  localparam int unsigned N_RANDOM = 1280;
  localparam int unsigned CALM_TAIL = 150;   // last items run with no idling
  localparam int unsigned HOLD_AT   = 600;   // random item at which the long hold starts
  localparam int unsigned HOLD_LEN  = 200;
  localparam int unsigned DRAIN_CYC = FRAC + 12;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct packed {
    logic [FRAC-1:0] hue;
    logic [FRAC:0]   sat;
    logic [FRAC:0]   lig;
  } hsl_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  known;  // expectation typed in below rather than predicted
    hsl_t  want;
  } pix_row_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [23:0]      in_tdata;   // red [7:0], green [15:8], blue [23:16]
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;  // hue, saturation, lightness, zero fill above

  // Expectation that goes with the word currently offered
  logic offer_known;
  hsl_t offer_want;

  hsl_t        hsl_due_q[$];
  int unsigned err_cnt;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_long_holds;
  int unsigned stall_cnt;
  bit          tx_idle_on;
  bit          rx_idle_on;
  bit          hold_req;
  int unsigned hold_cnt;

  pix_row_t dir_tab [0:19];

  rgb_to_hsl_converter #(.FRAC_BITS(FRAC)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // round(num * 2^FRAC / den), ties up
  function automatic int unsigned round_frac(input int unsigned num, input int unsigned den);
    return ((num << (FRAC + 1)) + den) / (den << 1);
  endfunction

  function automatic hsl_t predict_hsl(input chan_t r, input chan_t g, input chan_t b);
    int unsigned hi, lo, span, tot, sden, hnum, hq;
    hsl_t        res;
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    span = hi - lo;
    tot  = hi + lo;
    res  = '0;
    res.lig = (FRAC+1)'(round_frac(tot, 510));
    if (span != 0) begin
      sden    = (tot > 255) ? (510 - tot) : tot;
      res.sat = (FRAC+1)'(round_frac(span, sden));
      // sector from the largest channel, red then green then blue on ties
      if (hi == r)
        hnum = (g >= b) ? (g - b) : (6*span - (b - g));
      else if (hi == g)
        hnum = 2*span + b - r;
      else
        hnum = 4*span + r - g;
      hq = round_frac(hnum, 6*span);
      if (hq >= (1 << FRAC)) hq = 0;  // full turn wraps
      res.hue = FRAC'(hq);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
    err_cnt++;
  endtask

  // Offer one pixel, with an optional idle burst first; returns at the negedge
  // after acceptance
  task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b,
                            input logic known, input hsl_t want);
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_tdata    <= {b, g, r};
    offer_known <= known;
    offer_want  <= want;
    in_tvalid   <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_sent++;
    @(negedge clk);
  endtask

  // Random pixel, biased towards the interesting corners
  function automatic logic [23:0] pick_pixel();
    chan_t       c [3];
    chan_t       hi;
    int unsigned sel;
    chan_t       edges [6];
    edges = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
    c[0] = chan_t'($urandom);
    c[1] = chan_t'($urandom);
    c[2] = chan_t'($urandom);
    case ($urandom_range(0, 9))
      5: begin
        c[1] = c[0];
        c[2] = c[0];
      end
      6: begin
        sel = $urandom_range(0, 2);
        c[(sel + 1) % 3] = c[sel];
      end
      7: begin
        foreach (c[i]) c[i] = edges[$urandom_range(0, 5)];
      end
      8: begin
        // sum of largest and smallest near 255
        hi = chan_t'($urandom_range(128, 255));
        c[0] = hi;
        c[1] = chan_t'(255 - hi + $urandom_range(0, 2) - 1);
        if (c[1] > hi) c[1] = hi;
        c[2] = chan_t'($urandom_range(c[1], hi));
        sel = $urandom_range(0, 2);
        hi = c[0];
        c[0] = c[sel];
        c[sel] = hi;
      end
      9: begin
        // very small range
        c[1] = chan_t'(c[0] + $urandom_range(0, 3));
        c[2] = chan_t'(c[0] + $urandom_range(0, 3));
      end
      default: ;
    endcase
    return {c[2], c[1], c[0]};
  endfunction

  // Scoreboard: predict on input acceptance, check on output acceptance
  always @(posedge clk) begin
    hsl_t want;
    hsl_t got;
    hsl_t due;
    if (rst_n && in_tvalid && in_tready) begin
      due = offer_known ? offer_want
                        : predict_hsl(in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]);
      hsl_due_q = {hsl_due_q, due};
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.hue = out_tdata[FRAC-1:0];
      got.sat = out_tdata[2*FRAC:FRAC];
      got.lig = out_tdata[3*FRAC+1:2*FRAC+1];
      if (hsl_due_q.size() == 0) begin
        $display("[%0t] unexpected output word", $time);
        err_cnt++;
      end else begin
        want = hsl_due_q.pop_front();
        n_checked++;
        if (got.hue !== want.hue) report_mismatch("hue", got.hue, want.hue);
        if (got.sat !== want.sat) report_mismatch("saturation", got.sat, want.sat);
        if (got.lig !== want.lig) report_mismatch("lightness", got.lig, want.lig);
        if (out_tdata[OUT_W-1:3*FRAC+2] !== '0)
          report_mismatch("zero fill", out_tdata[OUT_W-1:3*FRAC+2], 0);
      end
    end
  end

  // Watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      stall_cnt <= 0;
    else if (stall_cnt >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else
      stall_cnt <= stall_cnt + 1;
  end

  // Receiver: random stall bursts, plus one long hold on request
  initial begin
    out_tready = 1'b0;
    hold_cnt   = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_LEN;
        n_long_holds++;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        hold_cnt   = $urandom_range(1, 12) - 1;
        out_tready <= 1'b0;
      end else
        out_tready <= 1'b1;
    end
  end

  // Main sequence
  initial begin
    logic [23:0] px;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    offer_known  = 1'b0;
    offer_want   = '0;
    rst_n        = 1'b0;
    err_cnt      = 0;
    n_sent       = 0;
    n_checked    = 0;
    n_long_holds = 0;
    stall_cnt    = 0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    hold_req     = 1'b0;

    // Directed table: extremes, greys, every sector, ties, near-boundary sums
    dir_tab = '{
      '{8'd0,   8'd0,   8'd0,   1'b1, '{12'd0, 13'd0,    13'd0}},     // black
      '{8'd255, 8'd255, 8'd255, 1'b1, '{12'd0, 13'd0,    13'd4096}},  // white
      '{8'd128, 8'd128, 8'd128, 1'b1, '{12'd0, 13'd0,    13'd2056}},  // mid grey
      '{8'd255, 8'd0,   8'd0,   1'b1, '{12'd0, 13'd4096, 13'd2048}},  // pure red
      '{8'd0,   8'd255, 8'd0,   1'b0, '0},                            // pure green
      '{8'd0,   8'd0,   8'd255, 1'b0, '0},                            // pure blue
      '{8'd255, 8'd255, 8'd0,   1'b0, '0},                            // red/green tie
      '{8'd0,   8'd255, 8'd255, 1'b0, '0},                            // green/blue tie
      '{8'd255, 8'd0,   8'd255, 1'b0, '0},                            // red/blue tie
      '{8'd255, 8'd0,   8'd1,   1'b0, '0},                            // hue just short of a turn
      '{8'd1,   8'd0,   8'd0,   1'b0, '0},
      '{8'd0,   8'd0,   8'd1,   1'b0, '0},
      '{8'd254, 8'd255, 8'd255, 1'b0, '0},                            // upper saturation form
      '{8'd127, 8'd128, 8'd128, 1'b0, '0},                            // sum exactly 255
      '{8'd128, 8'd127, 8'd127, 1'b0, '0},                            // sum exactly 255, red largest
      '{8'd255, 8'd200, 8'd100, 1'b0, '0},                            // full saturation, light
      '{8'd1,   8'd1,   8'd0,   1'b0, '0},
      '{8'd0,   8'd255, 8'd254, 1'b0, '0},
      '{8'd170, 8'd85,  8'd0,   1'b0, '0},
      '{8'd85,  8'd170, 8'd255, 1'b0, '0}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i])
      send_pixel(dir_tab[i].red, dir_tab[i].green, dir_tab[i].blue,
                 dir_tab[i].known, dir_tab[i].want);

    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      // long receiver hold with the sender offering back to back
      if (i == HOLD_AT) begin
        hold_req   = 1'b1;
        tx_idle_on = 1'b0;
      end
      if (i == HOLD_AT + HOLD_LEN) tx_idle_on = 1'b1;
      if (i == N_RANDOM - CALM_TAIL) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      px = pick_pixel();
      send_pixel(px[7:0], px[15:8], px[23:16], 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    while (hsl_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (hsl_due_q.size() != 0) begin
      $display("%0d expected words never arrived", hsl_due_q.size());
      err_cnt++;
    end

    $display("Converted %0d pixels (directed corners, greys, ties, random colours),",
             n_sent);
    $display("%0d words checked; random idling on both sides and %0d long output hold(s).",
             n_checked, n_long_holds);
    if (err_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
